// File: rtl/core/utf8d_pkg.sv
// shared types and constants for the utf-8 stream decoder
package utf8d_pkg;

  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned CP_W    = 31;
  localparam int unsigned CNT_W   = 3;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned PAY_W   = 6;
  localparam int unsigned OUT_TDATA_W = 40;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK        = 2'd0,
    ST_INVALID   = 2'd1,
    ST_TRUNCATED = 2'd2
  } status_t;

  // one captured input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] data_byte;
    logic              end_of_buffer;
  } in_item_t;

  // sequence state carried from byte to byte
  typedef struct packed {
    logic [CP_W-1:0]  partial_value;
    logic [CNT_W-1:0] bytes_remaining;
    logic [CNT_W-1:0] sequence_length;
  } seq_state_t;

  // result of one decode step
  typedef struct packed {
    logic             valid;
    logic [CP_W-1:0]  code_point;
    status_t          status;
    logic [CNT_W-1:0] byte_count;
  } result_t;

endpackage

// File: rtl/core/utf8d_in_stage.sv
// input register stage holding one accepted byte transaction
module utf8d_in_stage (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  utf8d_pkg::in_item_t in_item,
  input  logic              advance,
  output logic              item_valid,
  output utf8d_pkg::in_item_t item
);
  import utf8d_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t item_r;

  // stage is free when empty or when its content moves on this cycle
  assign in_ready = !valid_r || advance;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  // control register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // payload register, no reset
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      item_r <= in_item;
    end
  end

  assign item_valid = valid_r;
  assign item       = item_r;

endmodule

// File: rtl/core/utf8d_step.sv
// single-pass decode of one byte against the current sequence state
module utf8d_step (
  input  utf8d_pkg::in_item_t   item,
  input  utf8d_pkg::seq_state_t state,
  output utf8d_pkg::seq_state_t state_nxt,
  output utf8d_pkg::result_t    result
);
  import utf8d_pkg::*;

  logic [BYTE_W-1:0] b;
  logic              eob;
  logic              lead_ok;
  logic [CNT_W-1:0]  lead_len;
  logic [CP_W-1:0]   lead_pay;
  logic [CP_W-1:0]   shifted;
  logic [CNT_W-1:0]  rem_dec;

  assign b   = item.data_byte;
  assign eob = item.end_of_buffer;

  // lead byte length and payload bits
  always_comb begin
    lead_ok  = 1'b1;
    lead_len = 3'd1;
    lead_pay = '0;
    if (b[7] == 1'b0) begin
      lead_len = 3'd1;
      lead_pay = CP_W'(b[6:0]);
    end else if (b[7:5] == 3'b110) begin
      lead_len = 3'd2;
      lead_pay = CP_W'(b[4:0]);
    end else if (b[7:4] == 4'b1110) begin
      lead_len = 3'd3;
      lead_pay = CP_W'(b[3:0]);
    end else if (b[7:3] == 5'b11110) begin
      lead_len = 3'd4;
      lead_pay = CP_W'(b[2:0]);
    end else if (b[7:2] == 6'b111110) begin
      lead_len = 3'd5;
      lead_pay = CP_W'(b[1:0]);
    end else if (b[7:1] == 7'b1111110) begin
      lead_len = 3'd6;
      lead_pay = CP_W'(b[0]);
    end else begin
      lead_ok = 1'b0;
    end
  end

  // following byte: shift in six payload bits, marker bits ignored
  assign shifted = {state.partial_value[CP_W-PAY_W-1:0], b[PAY_W-1:0]};
  assign rem_dec = state.bytes_remaining - 3'd1;

  // next state and result
  always_comb begin
    state_nxt         = state;
    result.valid      = 1'b0;
    result.code_point = '0;
    result.status     = ST_OK;
    result.byte_count = 3'd1;
    if (state.bytes_remaining == '0) begin
      if (!lead_ok) begin
        result.valid  = 1'b1;
        result.status = ST_INVALID;
      end else if (lead_len == 3'd1) begin
        result.valid      = 1'b1;
        result.code_point = lead_pay;
      end else if (eob) begin
        result.valid  = 1'b1;
        result.status = ST_TRUNCATED;
        state_nxt     = '0;
      end else begin
        state_nxt.partial_value   = lead_pay;
        state_nxt.sequence_length = lead_len;
        state_nxt.bytes_remaining = lead_len - 3'd1;
      end
    end else if (rem_dec == '0) begin
      result.valid      = 1'b1;
      result.code_point = shifted;
      result.byte_count = state.sequence_length;
      state_nxt         = '0;
    end else if (eob) begin
      result.valid      = 1'b1;
      result.status     = ST_TRUNCATED;
      result.byte_count = state.sequence_length - rem_dec;
      state_nxt         = '0;
    end else begin
      state_nxt.partial_value   = shifted;
      state_nxt.bytes_remaining = rem_dec;
    end
  end

endmodule

// File: rtl/core/utf8_stream_decoder_core.sv
// Byte-serial decoder for the legacy six-byte UTF-8 form, giving 31-bit code
// points. One byte is accepted every clock cycle while the result side keeps
// up; a byte is registered at the input, decoded against the sequence state
// in a single pass and its result, if any, is registered at the output.
// Lead bytes that open a multi-byte sequence and the following bytes before
// the last produce no result. Continuation markers are not checked; invalid
// lead bytes give status 1 and are dropped; an end-of-buffer mark inside a
// sequence gives status 2 and returns the decoder to idle.
module utf8_stream_decoder_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_buffer
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [utf8d_pkg::OUT_TDATA_W-1:0] out_tdata, // [30:0] code_point, [33:31] byte_count
  output logic [utf8d_pkg::STAT_W-1:0]      out_tuser  // [1:0] status
);
  import utf8d_pkg::*;

  in_item_t   in_item;
  in_item_t   item;
  logic       item_valid;
  logic       out_free;
  logic       advance;
  seq_state_t state_r;
  seq_state_t state_nxt;
  seq_state_t step_state;
  result_t    step_res;
  logic       out_valid_r;
  logic       out_valid_nxt;
  logic [CP_W-1:0]  out_cp_r;
  status_t          out_status_r;
  logic [CNT_W-1:0] out_count_r;

  assign in_item.data_byte     = in_tdata;
  assign in_item.end_of_buffer = in_tlast;

  // output register can take a new result this cycle
  assign out_free = !out_valid_r || out_tready;
  assign advance  = item_valid && out_free;

  utf8d_in_stage u_in_stage (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_item    (in_item),
    .advance    (advance),
    .item_valid (item_valid),
    .item       (item)
  );

  utf8d_step u_step (
    .item      (item),
    .state     (state_r),
    .state_nxt (step_state),
    .result    (step_res)
  );

  // sequence state moves only when the held byte is consumed
  assign state_nxt = advance ? step_state : state_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_free) begin
      out_valid_nxt = advance && step_res.valid;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // result payload register
  always_ff @(posedge clk) begin
    if (advance && step_res.valid) begin
      out_cp_r     <= step_res.code_point;
      out_status_r <= step_res.status;
      out_count_r  <= step_res.byte_count;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_TDATA_W - CP_W - CNT_W){1'b0}}, out_count_r, out_cp_r};
  assign out_tuser  = out_status_r;

endmodule
